FILE: hw/rtl/mlfq_pkg.sv
// Shared types and constants of the feedback queue scheduler.
`default_nettype none
package mlfq_pkg;
    localparam int SLOTS = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
    localparam int ENTRY_W = 2 + 2 + 2 + 1 + COUNT_WIDTH + COUNT_WIDTH + 32 + 32 + 32;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_CREATE   = 3'd1;
    localparam logic [2:0] MODE_READY    = 3'd2;
    localparam logic [2:0] MODE_DISPATCH = 3'd3;
    localparam logic [2:0] MODE_BLOCK    = 3'd4;
    localparam logic [2:0] MODE_EXIT     = 3'd5;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_BLOCK = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_SLOT  = 2'd1;
    localparam logic [1:0] ERR_NORUN = 2'd2;

    localparam logic [2:0] CFG_AGING = 3'd4;

    typedef struct packed {
        logic [1:0]             status;
        logic [1:0]             level;
        logic [1:0]             kind;
        logic                   queued;
        logic [COUNT_WIDTH-1:0] burst;
        logic [COUNT_WIDTH-1:0] waitc;
        logic [31:0]            iowait;
        logic [31:0]            entry;
        logic [31:0]            seq;
    } entry_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,       // latch the input item
        OP_RD,         // read the entry at the scan index
        OP_TICK_UPD,   // counter update of the read entry, write back
        OP_RUN_RD,     // read the running entry
        OP_RUN_CHK,    // quantum check of the running entry
        OP_AGE_UPD,    // aging of the read entry, write back
        OP_SCAN_CMP,   // compare read entry against best so far
        OP_BEST_RD,    // read the entry that won the scan
        OP_DISP_WR,    // write the winner as running
        OP_SLOT_RD,    // read the entry at the latched slot, or the running one for block
        OP_SLOT_EXEC,  // create, ready, exit or block on that entry
        OP_FINISH      // present the result
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [SLOT_W-1:0] idx;
        logic [1:0]      lvl;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       run_valid;
        logic       have_best;
    } stat_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == U32_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc_cnt(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic is_exempt(input logic [1:0] k);
        return (k == 2'd1) || (k == 2'd2);
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/mlfq_process_scheduler.sv
// Top level of the four-level feedback queue scheduler.
// Tick walks the table updating counters, checks the running task's quantum if one runs,
// then walks it again for aging. Dispatch scans level by level from 0 and writes the winner
// as running. Create, ready, exit and block read the slot, then act on it; block with nothing
// running skips the read. One event at a time; busy stays high through done.
// Reset clears all slots at once through per-slot valid bits and restores register defaults.
`default_nettype none
module mlfq_process_scheduler
    import mlfq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [2:0]  mode,
    input  wire logic [5:0]  slot,
    input  wire logic [1:0]  level,
    input  wire logic [1:0]  kind,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output      logic        done,
    output      logic        found,
    output      logic [5:0]  chosen_slot,
    output      logic [1:0]  chosen_level,
    output      logic        demoted,
    output      logic [6:0]  promoted_count,
    output      logic [1:0]  error
);
    cmd_t  cmd;
    stat_t stat;

    mlfq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .mode(mode), .slot(slot), .level(level), .kind(kind),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .found(found), .chosen_slot(chosen_slot),
        .chosen_level(chosen_level), .demoted(demoted),
        .promoted_count(promoted_count), .error(error)
    );

    mlfq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .done(done), .busy(busy),
        .cmd(cmd), .stat(stat)
    );
endmodule
`default_nettype wire

FILE: hw/rtl/mlfq_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/mlfq_datapath.sv
// Slot table, scheduler registers and per-operation update logic.
`default_nettype none
module mlfq_datapath
    import mlfq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output      stat_t             stat,
    input  wire logic [2:0]        mode,
    input  wire logic [5:0]        slot,
    input  wire logic [1:0]        level,
    input  wire logic [1:0]        kind,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output      logic              done,
    output      logic              found,
    output      logic [5:0]        chosen_slot,
    output      logic [1:0]        chosen_level,
    output      logic              demoted,
    output      logic [6:0]        promoted_count,
    output      logic [1:0]        error
);
    // Valid bits stand for the all-zero reset value of each entry.
    logic [SLOTS-1:0]  valid_reg;
    logic [15:0]       quantum_reg [4];
    logic [15:0]       aging_reg;
    logic [31:0]       seq_reg, tick_reg;
    logic              run_valid_reg;
    logic [SLOT_W-1:0] run_idx_reg;
    logic [2:0]        mode_reg;
    logic [5:0]        slot_reg;
    logic [1:0]        level_reg, kind_reg;
    logic [SLOT_W-1:0] ridx_reg;
    logic              have_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [31:0]       best_io_reg, best_entry_reg, best_seq_reg;
    logic              found_reg, demoted_reg;
    logic [6:0]        prom_reg;
    logic [1:0]        err_reg;

    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] rd_idx;
    entry_t            wdata, rdata_raw, cur;
    logic              slot_ok;
    logic              scan_hit;

    mlfq_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata_raw)
    );

    assign cur = valid_reg[ridx_reg] ? rdata_raw : '0;
    assign slot_ok = ({26'd0, slot_reg} < 32'(SLOTS));
    assign scan_hit = (cur.status == ST_READY) && cur.queued && (cur.level == cmd.lvl);

    logic better;
    always_comb
    begin
        if (cur.iowait != best_io_reg)
            better = cur.iowait > best_io_reg;
        else if (cur.entry != best_entry_reg)
            better = cur.entry > best_entry_reg;
        else
            better = cur.seq < best_seq_reg;
    end

    // The flag includes the entry compared in this cycle, so the last slot of a pass counts.
    assign stat = '{mode: mode_reg, run_valid: run_valid_reg,
                    have_best: have_reg || ((cmd.op == OP_SCAN_CMP) && scan_hit)};

    // Read address: the scan index, or one of the indexes held here.
    always_comb
    begin
        case (cmd.op)
            OP_RUN_RD:  rd_idx = run_idx_reg;
            OP_BEST_RD: rd_idx = best_idx_reg;
            OP_SLOT_RD: rd_idx = (mode_reg == MODE_BLOCK) ? run_idx_reg : SLOT_W'(slot_reg);
            default:    rd_idx = cmd.idx;
        endcase
    end

    logic run_hit;
    logic age_hit;
    assign run_hit = (cur.burst >= COUNT_WIDTH'(quantum_reg[cur.level])) && !is_exempt(cur.kind);
    assign age_hit = (cur.status == ST_READY) && cur.queued && (cur.level != 2'd0)
                     && !is_exempt(cur.kind) && (cur.waitc >= COUNT_WIDTH'(aging_reg));

    always_comb
    begin
        we    = 1'b0;
        addr  = rd_idx;
        wdata = cur;
        case (cmd.op)
            OP_TICK_UPD:
            begin
                we   = 1'b1;
                addr = ridx_reg;
                case (cur.status)
                    ST_RUN:   wdata.burst  = sat_inc_cnt(cur.burst);
                    ST_READY: wdata.waitc  = sat_inc_cnt(cur.waitc);
                    ST_BLOCK: wdata.iowait = sat_inc32(cur.iowait);
                    default:  wdata = cur;
                endcase
            end
            OP_RUN_CHK:
            begin
                addr = ridx_reg;
                if (run_hit)
                begin
                    we = 1'b1;
                    wdata.burst = '0;
                    if (cur.level != 2'd3)
                    begin
                        wdata.level  = cur.level + 2'd1;
                        wdata.waitc  = '0;
                        wdata.iowait = '0;
                    end
                end
            end
            OP_AGE_UPD:
            begin
                addr = ridx_reg;
                if (age_hit)
                begin
                    we = 1'b1;
                    wdata.level = cur.level - 2'd1;
                    wdata.waitc = '0;
                    wdata.burst = '0;
                    wdata.entry = tick_reg;
                    wdata.seq   = seq_reg;
                end
            end
            OP_DISP_WR:
            begin
                addr = ridx_reg;
                we = 1'b1;
                wdata.status = ST_RUN;
                wdata.queued = 1'b0;
            end
            OP_SLOT_EXEC:
            begin
                addr = ridx_reg;
                case (mode_reg)
                    MODE_CREATE:
                    if (slot_ok && cur.status == ST_FREE)
                    begin
                        we = 1'b1;
                        wdata = '0;
                        wdata.status = ST_READY;
                        wdata.level  = level_reg;
                        wdata.kind   = kind_reg;
                        wdata.queued = 1'b1;
                        wdata.entry  = tick_reg;
                        wdata.seq    = seq_reg;
                    end
                    MODE_READY:
                    if (slot_ok && (cur.status == ST_BLOCK || cur.status == ST_RUN))
                    begin
                        we = 1'b1;
                        wdata.status = ST_READY;
                        wdata.queued = 1'b1;
                        wdata.entry  = tick_reg;
                        wdata.seq    = seq_reg;
                    end
                    MODE_EXIT:
                    if (slot_ok && cur.status != ST_FREE)
                    begin
                        we = 1'b1;
                        wdata = '0;
                    end
                    MODE_BLOCK:
                    if (run_valid_reg)
                    begin
                        we = 1'b1;
                        wdata.status = ST_BLOCK;
                    end
                    default: we = 1'b0;
                endcase
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            quantum_reg[0] <= 16'd10;
            quantum_reg[1] <= 16'd20;
            quantum_reg[2] <= 16'd40;
            quantum_reg[3] <= 16'd80;
            aging_reg      <= 16'd250;
            seq_reg        <= '0;
            tick_reg       <= '0;
            run_valid_reg  <= 1'b0;
            run_idx_reg    <= '0;
            mode_reg       <= '0;
            have_reg       <= 1'b0;
            done           <= 1'b0;
        end
        else
        begin
            done <= (cmd.op == OP_FINISH);
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                if (cfg_index < CFG_AGING)
                begin
                    quantum_reg[cfg_index[1:0]] <= cfg_data;
                end
                else if (cfg_index == CFG_AGING)
                begin
                    aging_reg <= cfg_data;
                end
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    mode_reg <= mode;
                    have_reg <= 1'b0;
                end
                OP_RUN_CHK:
                begin
                    ;
                end
                OP_AGE_UPD:
                if (age_hit)
                begin
                    seq_reg <= sat_inc32(seq_reg);
                end
                OP_SCAN_CMP:
                if (scan_hit && (!have_reg || better))
                begin
                    have_reg <= 1'b1;
                end
                OP_DISP_WR:
                begin
                    run_valid_reg <= 1'b1;
                    run_idx_reg   <= ridx_reg;
                end
                OP_SLOT_EXEC:
                case (mode_reg)
                    MODE_CREATE:
                    if (slot_ok && cur.status == ST_FREE)
                    begin
                        seq_reg <= sat_inc32(seq_reg);
                    end
                    MODE_READY:
                    if (slot_ok && (cur.status == ST_BLOCK || cur.status == ST_RUN))
                    begin
                        seq_reg <= sat_inc32(seq_reg);
                        if (cur.status == ST_RUN)
                        begin
                            run_valid_reg <= 1'b0;
                        end
                    end
                    MODE_EXIT:
                    if (slot_ok && cur.status != ST_FREE && run_valid_reg
                        && run_idx_reg == ridx_reg)
                    begin
                        run_valid_reg <= 1'b0;
                    end
                    MODE_BLOCK:
                    begin
                        run_valid_reg <= 1'b0;
                    end
                    default: mode_reg <= mode_reg;
                endcase
                OP_FINISH:
                if (mode_reg == MODE_TICK)
                begin
                    tick_reg <= sat_inc32(tick_reg);
                end
                default: mode_reg <= mode_reg;
            endcase
        end
    end

    // Payload and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                slot_reg    <= slot;
                level_reg   <= level;
                kind_reg    <= kind;
                found_reg   <= 1'b0;
                demoted_reg <= 1'b0;
                prom_reg    <= '0;
                err_reg     <= ERR_OK;
                best_idx_reg <= '0;
            end
            OP_RD, OP_RUN_RD, OP_BEST_RD, OP_SLOT_RD:
            begin
                ridx_reg <= rd_idx;
            end
            OP_RUN_CHK:
            if (run_hit)
            begin
                demoted_reg <= 1'b1;
            end
            OP_AGE_UPD:
            if (age_hit && prom_reg != 7'd127)
            begin
                prom_reg <= prom_reg + 7'd1;
            end
            OP_SCAN_CMP:
            if (scan_hit && (!have_reg || better))
            begin
                best_idx_reg   <= ridx_reg;
                best_io_reg    <= cur.iowait;
                best_entry_reg <= cur.entry;
                best_seq_reg   <= cur.seq;
            end
            OP_DISP_WR:
            begin
                found_reg <= 1'b1;
            end
            OP_SLOT_EXEC:
            case (mode_reg)
                MODE_CREATE:
                if (!(slot_ok && cur.status == ST_FREE))
                    err_reg <= ERR_SLOT;
                MODE_READY:
                if (!(slot_ok && (cur.status == ST_BLOCK || cur.status == ST_RUN)))
                    err_reg <= ERR_SLOT;
                MODE_EXIT:
                if (!(slot_ok && cur.status != ST_FREE))
                    err_reg <= ERR_SLOT;
                MODE_BLOCK:
                if (!run_valid_reg)
                    err_reg <= ERR_NORUN;
                MODE_DISPATCH:
                    err_reg <= ERR_SLOT;
                default: err_reg <= err_reg;
            endcase
            default: err_reg <= err_reg;
        endcase
    end

    // The winner is rewritten through OP_DISP_WR with ridx taken from the best index.
    assign found          = found_reg;
    assign chosen_slot    = found_reg ? 6'(best_idx_reg) : 6'd0;
    assign chosen_level   = found_reg ? cmd.lvl : 2'd0;
    assign demoted        = demoted_reg;
    assign promoted_count = prom_reg;
    assign error          = err_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/mlfq_ctrl.sv
// Sequencer that steps through each scheduler event, walking the slot table for tick and dispatch.
`default_nettype none
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  done,
    output      logic  busy,
    output      cmd_t  cmd,
    input  wire stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE,
        S_TK_RD, S_TK_UPD, S_RUN_RD, S_RUN_CHK, S_AG_RD, S_AG_UPD,
        S_SC_RD, S_SC_CMP, S_DP_RD, S_DP_WR,
        S_SL_RD, S_SL_EXEC, S_FIN, S_OUT
    } state_t;

    state_t            state_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [1:0]        lvl_reg;
    logic              last;

    assign last = (idx_reg == SLOT_W'(SLOTS - 1));
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '{op: OP_NONE, idx: idx_reg, lvl: lvl_reg};
        case (state_reg)
            S_IDLE:    if (start) cmd.op = OP_LOAD;
            S_TK_RD, S_AG_RD, S_SC_RD: cmd.op = OP_RD;
            S_TK_UPD:  cmd.op = OP_TICK_UPD;
            S_RUN_RD:  cmd.op = OP_RUN_RD;
            S_RUN_CHK: cmd.op = OP_RUN_CHK;
            S_AG_UPD:  cmd.op = OP_AGE_UPD;
            S_SC_CMP:  cmd.op = OP_SCAN_CMP;
            S_DP_RD:   cmd.op = OP_BEST_RD;
            S_DP_WR:   cmd.op = OP_DISP_WR;
            S_SL_RD:   cmd.op = OP_SLOT_RD;
            S_SL_EXEC: cmd.op = OP_SLOT_EXEC;
            S_FIN:     cmd.op = OP_FINISH;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                if (start)
                begin
                    state_reg <= S_DECODE;
                    idx_reg   <= '0;
                    lvl_reg   <= '0;
                end
                S_DECODE:
                case (stat.mode)
                    MODE_TICK:     state_reg <= S_TK_RD;
                    MODE_DISPATCH: state_reg <= stat.run_valid ? S_SL_EXEC : S_SC_RD;
                    MODE_CREATE, MODE_READY, MODE_EXIT: state_reg <= S_SL_RD;
                    MODE_BLOCK:    state_reg <= stat.run_valid ? S_SL_RD : S_SL_EXEC;
                    default:       state_reg <= S_FIN;
                endcase
                S_TK_RD:  state_reg <= S_TK_UPD;
                S_TK_UPD:
                begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                    state_reg <= last ? (stat.run_valid ? S_RUN_RD : S_AG_RD) : S_TK_RD;
                end
                S_RUN_RD:  state_reg <= S_RUN_CHK;
                S_RUN_CHK: state_reg <= S_AG_RD;
                S_AG_RD:   state_reg <= S_AG_UPD;
                S_AG_UPD:
                begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                    state_reg <= last ? S_FIN : S_AG_RD;
                end
                S_SC_RD:  state_reg <= S_SC_CMP;
                S_SC_CMP:
                begin
                    idx_reg <= idx_reg + SLOT_W'(1);
                    if (last)
                    begin
                        if (stat.have_best)
                            state_reg <= S_DP_RD;
                        else if (lvl_reg == 2'd3)
                            state_reg <= S_FIN;
                        else
                        begin
                            lvl_reg   <= lvl_reg + 2'd1;
                            state_reg <= S_SC_RD;
                        end
                    end
                    else
                        state_reg <= S_SC_RD;
                end
                S_DP_RD:   state_reg <= S_DP_WR;
                S_DP_WR:   state_reg <= S_FIN;
                S_SL_RD:   state_reg <= S_SL_EXEC;
                S_SL_EXEC: state_reg <= S_FIN;
                S_FIN:     state_reg <= S_OUT;
                S_OUT:     if (done) state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb_mlfq_process_scheduler.sv
// Self-checking testbench for the feedback queue scheduler: directed and random events.
`default_nettype none
module tb_mlfq_process_scheduler
    import mlfq_pkg::*;
();
    localparam logic [2:0] CFG_QUANTUM0 = 3'd0;
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic       found;
        logic [5:0] cslot;
        logic [1:0] clvl;
        logic       demoted;
        logic [6:0] promoted;
        logic [1:0] err;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = '0;
    logic [5:0]  slot = '0;
    logic [1:0]  level = '0;
    logic [1:0]  kind = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        done;
    logic        found;
    logic [5:0]  chosen_slot;
    logic [1:0]  chosen_level;
    logic        demoted;
    logic [6:0]  promoted_count;
    logic [1:0]  error;

    mlfq_process_scheduler i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .slot(slot), .level(level), .kind(kind),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .found(found), .chosen_slot(chosen_slot),
        .chosen_level(chosen_level), .demoted(demoted),
        .promoted_count(promoted_count), .error(error)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Scheduler state as the testbench sees it.
    logic [1:0]  task_status [SLOTS];
    logic [1:0]  task_level [SLOTS];
    logic [1:0]  task_kind [SLOTS];
    logic        task_queued [SLOTS];
    logic [15:0] task_burst [SLOTS];
    logic [15:0] task_wait [SLOTS];
    logic [31:0] task_iowait [SLOTS];
    logic [31:0] task_entry [SLOTS];
    logic [31:0] task_seq [SLOTS];
    logic [31:0] seq_next;
    logic [31:0] tick_now;
    logic        cpu_busy;
    int          cpu_slot;
    logic [15:0] quantum [4];
    logic [15:0] aging_limit;

    sched_result_t pending_results[$];
    int errors = 0;
    int stall_cycles = 0;

    function automatic logic exempt_kind(input logic [1:0] k);
        return k == 2'd1 || k == 2'd2;
    endfunction

    function automatic void wipe_task(input int s);
        task_status[s] = ST_FREE;
        task_level[s] = '0;
        task_kind[s] = '0;
        task_queued[s] = 1'b0;
        task_burst[s] = '0;
        task_wait[s] = '0;
        task_iowait[s] = '0;
        task_entry[s] = '0;
        task_seq[s] = '0;
    endfunction

    function automatic void queue_task(input int s);
        task_queued[s] = 1'b1;
        task_entry[s] = tick_now;
        task_seq[s] = seq_next;
        if (seq_next != 32'hFFFF_FFFF) seq_next = seq_next + 1;
    endfunction

    function automatic sched_result_t schedule_event(input logic [2:0] m, input int s,
                                                     input logic [1:0] lv, input logic [1:0] k);
        sched_result_t res;
        int best;
        int r;
        res = '0;
        case (m)
            MODE_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (task_status[i] == ST_RUN) begin
                        if (task_burst[i] != 16'hFFFF) task_burst[i]++;
                    end else if (task_status[i] == ST_READY) begin
                        if (task_wait[i] != 16'hFFFF) task_wait[i]++;
                    end else if (task_status[i] == ST_BLOCK) begin
                        if (task_iowait[i] != 32'hFFFF_FFFF) task_iowait[i]++;
                    end
                end
                if (cpu_busy) begin
                    r = cpu_slot;
                    if (task_burst[r] >= quantum[task_level[r]] && !exempt_kind(task_kind[r]))
                    begin
                        res.demoted = 1'b1;
                        task_burst[r] = '0;
                        if (task_level[r] < 2'd3) begin
                            task_level[r]++;
                            task_wait[r] = '0;
                            task_iowait[r] = '0;
                        end
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (task_status[i] == ST_READY && task_queued[i] && task_level[i] != 0 &&
                        !exempt_kind(task_kind[i]) && task_wait[i] >= aging_limit) begin
                        task_level[i]--;
                        task_wait[i] = '0;
                        task_burst[i] = '0;
                        queue_task(i);
                        if (res.promoted != 7'd127) res.promoted++;
                    end
                end
                if (tick_now != 32'hFFFF_FFFF) tick_now++;
            end
            MODE_CREATE: begin
                if (task_status[s] != ST_FREE) res.err = ERR_SLOT;
                else begin
                    wipe_task(s);
                    task_status[s] = ST_READY;
                    task_level[s] = lv;
                    task_kind[s] = k;
                    queue_task(s);
                end
            end
            MODE_READY: begin
                if (task_status[s] != ST_BLOCK && task_status[s] != ST_RUN) res.err = ERR_SLOT;
                else begin
                    if (task_status[s] == ST_RUN) cpu_busy = 1'b0;
                    task_status[s] = ST_READY;
                    queue_task(s);
                end
            end
            MODE_DISPATCH: begin
                if (cpu_busy) res.err = ERR_SLOT;
                else begin
                    for (int l = 0; l < 4 && !res.found; l++) begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (task_status[i] == ST_READY && task_queued[i] &&
                                task_level[i] == l) begin
                                if (best < 0) best = i;
                                else if (task_iowait[i] != task_iowait[best]) begin
                                    if (task_iowait[i] > task_iowait[best]) best = i;
                                end else if (task_entry[i] != task_entry[best]) begin
                                    if (task_entry[i] > task_entry[best]) best = i;
                                end else if (task_seq[i] < task_seq[best]) best = i;
                            end
                        end
                        if (best >= 0) begin
                            res.found = 1'b1;
                            res.cslot = best[5:0];
                            res.clvl = l[1:0];
                            task_status[best] = ST_RUN;
                            task_queued[best] = 1'b0;
                            cpu_busy = 1'b1;
                            cpu_slot = best;
                        end
                    end
                end
            end
            MODE_BLOCK: begin
                if (!cpu_busy) res.err = ERR_NORUN;
                else begin
                    task_status[cpu_slot] = ST_BLOCK;
                    cpu_busy = 1'b0;
                end
            end
            MODE_EXIT: begin
                if (task_status[s] == ST_FREE) res.err = ERR_SLOT;
                else begin
                    if (cpu_busy && cpu_slot == s) cpu_busy = 1'b0;
                    wipe_task(s);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [1:0] rand2();
        return 2'($urandom_range(0, 3));
    endfunction

    // Returns a slot in the wanted state most of the time, else any slot.
    function automatic int pick_slot(input logic [1:0] want);
        int base;
        base = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (task_status[(base + i) % SLOTS] == want) return (base + i) % SLOTS;
            end
        end
        return base;
    endfunction

    // Caller stands at a rising edge; returns at the edge where the transfer happened, or after the gap with start low.
    task automatic send_event(input logic [2:0] m, input int s, input logic [1:0] lv,
                              input logic [1:0] k, input int gap);
        start <= 1'b1;
        mode <= m;
        slot <= s[5:0];
        level <= lv;
        kind <= k;
        do @(posedge clk); while (busy);
        pending_results.push_back(schedule_event(m, s, lv, k));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (start) begin
            start <= 1'b0;
            @(posedge clk);
        end
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_AGING) aging_limit = val;
        else quantum[idx[1:0]] = val;
    endtask

    task automatic set_policy(input logic [15:0] q0, input logic [15:0] q1,
                              input logic [15:0] q2, input logic [15:0] q3,
                              input logic [15:0] age);
        wait_drained();
        write_reg(CFG_QUANTUM0, q0);
        write_reg(CFG_QUANTUM0 + 3'd1, q1);
        write_reg(CFG_QUANTUM0 + 3'd2, q2);
        write_reg(CFG_QUANTUM0 + 3'd3, q3);
        write_reg(CFG_AGING, age);
    endtask

    task automatic test_directed();
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);   // empty queues
        send_event(MODE_BLOCK, 0, 2'd0, 2'd0, 1);      // nothing running
        send_event(MODE_READY, 5, 2'd0, 2'd0, 0);      // free slot cannot become ready
        send_event(MODE_EXIT, 63, 2'd0, 2'd0, 0);      // exit of a free slot
        send_event(MODE_CREATE, 0, 2'd3, 2'd0, 0);
        send_event(MODE_CREATE, 63, 2'd3, 2'd3, 2);
        send_event(MODE_CREATE, 63, 2'd0, 2'd0, 0);    // slot already used
        send_event(MODE_CREATE, 21, 2'd1, 2'd1, 0);
        send_event(MODE_CREATE, 42, 2'd2, 2'd2, 0);
        send_event(MODE_CREATE, 7, 2'd3, 2'd0, 0);     // full tie with slot 0 except order
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);   // already running
        send_event(MODE_TICK, 0, 2'd0, 2'd0, 0);
        send_event(MODE_BLOCK, 0, 2'd0, 2'd0, 0);
        send_event(MODE_READY, 21, 2'd0, 2'd0, 0);     // blocked task comes back
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);
        send_event(MODE_READY, 42, 2'd0, 2'd0, 0);     // ready slot cannot be readied again
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);
        send_event(MODE_EXIT, 42, 2'd0, 2'd0, 0);      // exit of a ready task
        send_event(MODE_SPARE_LO, 63, 2'd3, 2'd3, 0);
        send_event(MODE_SPARE_HI, 0, 2'd0, 2'd0, 0);
        send_event(MODE_READY, 21, 2'd0, 2'd0, 0);     // yield of the running task
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);   // the yielded task is the only one at level 1
        send_event(MODE_TICK, 0, 2'd0, 2'd0, 0);
    endtask

    // Small budgets so that demotion and aging fire often.
    task automatic test_demote_and_age();
        set_policy(16'd1, 16'd1, 16'd2, 16'd0, 16'd1);
        for (int i = 0; i < 6; i++) send_event(MODE_CREATE, 10 + i, i[1:0], 2'd0, 0);
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);
        for (int i = 0; i < 8; i++) send_event(MODE_TICK, 0, 2'd0, 2'd0, gap_length());
        send_event(MODE_BLOCK, 0, 2'd0, 2'd0, 0);
        send_event(MODE_DISPATCH, 0, 2'd0, 2'd0, 0);
        for (int i = 0; i < 4; i++) send_event(MODE_TICK, 0, 2'd0, 2'd0, 0);
    endtask

    task automatic test_random(input int count);
        int r;
        int s;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 22) send_event(MODE_TICK, $urandom_range(0, 63), rand2(), rand2(),
                                   gap_length());
            else if (r < 42) begin
                s = ($urandom_range(0, 1) != 0) ? pick_slot(ST_FREE) : $urandom_range(0, 63);
                send_event(MODE_CREATE, s, rand2(), rand2(), gap_length());
            end else if (r < 56) begin
                s = ($urandom_range(0, 1) != 0) ? pick_slot(ST_BLOCK) : pick_slot(ST_RUN);
                send_event(MODE_READY, s, rand2(), rand2(), gap_length());
            end else if (r < 76) send_event(MODE_DISPATCH, $urandom_range(0, 63),
                                            rand2(), rand2(), gap_length());
            else if (r < 87) send_event(MODE_BLOCK, $urandom_range(0, 63),
                                        rand2(), rand2(), gap_length());
            else if (r < 96) begin
                s = ($urandom_range(0, 1) != 0) ? pick_slot(ST_READY) : pick_slot(ST_BLOCK);
                send_event(MODE_EXIT, s, rand2(), rand2(), gap_length());
            end else send_event(($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO,
                                $urandom_range(0, 63), rand2(), rand2(), gap_length());
            // Now and then hold off until the scheduler has answered everything.
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin
        sched_result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no transfer waiting, expected none, actual slot %0d",
                         $time, chosen_slot);
            end else begin
                want = pending_results.pop_front();
                check_field("found", int'(want.found), int'(found));
                check_field("chosen_slot", int'(want.cslot), int'(chosen_slot));
                check_field("chosen_level", int'(want.clvl), int'(chosen_level));
                check_field("demoted", int'(want.demoted), int'(demoted));
                check_field("promoted_count", int'(want.promoted), int'(promoted_count));
                check_field("error", int'(want.err), int'(error));
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || !rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) wipe_task(i);
        seq_next = '0;
        tick_now = '0;
        cpu_busy = 1'b0;
        cpu_slot = 0;
        quantum[0] = 16'd10;
        quantum[1] = 16'd20;
        quantum[2] = 16'd40;
        quantum[3] = 16'd80;
        aging_limit = 16'd250;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_demote_and_age();
        test_random(220);
        set_policy(16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        test_random(150);
        set_policy(16'd3, 16'd5, 16'd2, 16'd4, 16'd6);
        test_random(230);
        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
